### src/pix2x2_pkg.sv
// Shared constants, codes and types for the 2x2 block-average mosaic.
`default_nettype none
package pix2x2_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 12;
  localparam int WID_W   = 10;
  localparam int HGT_W   = 13;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W   = PIX_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(512);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(512);

  // What one pixel does, by its place in the frame
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_STORE = 3'd0;  // even row: into line store
  localparam logic [KIND_W-1:0] KIND_ONE   = 3'd1;  // even last row: pass through
  localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd2;  // odd row, even column: hold
  localparam logic [KIND_W-1:0] KIND_TWO   = 3'd3;  // odd row, odd-width last column
  localparam logic [KIND_W-1:0] KIND_FOUR  = 3'd4;  // odd row, odd column: full block

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [KIND_W-1:0] kind;
    logic              fend;
  } scan_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  val0;
    logic [PIX_W-1:0]  val1;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              fend;
  } burst_t;

endpackage
`default_nettype wire

### src/pix2x2_line_store.sv
// Line store for even-row pixels: one shared port, registered read data.
`default_nettype none
module pix2x2_line_store (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic                          rd_en,
  input  wire logic [pix2x2_pkg::COL_W-1:0]  addr,
  input  wire logic [pix2x2_pkg::PIX_W-1:0]  wr_data,
  output logic      [pix2x2_pkg::PIX_W-1:0]  rd_data_r
);

  logic [pix2x2_pkg::PIX_W-1:0] mem [pix2x2_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### src/pix2x2_scan.sv
// Raster position counters and per-pixel classification.
`default_nettype none
module pix2x2_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic [pix2x2_pkg::WID_W-1:0]  image_width,
  input  wire logic [pix2x2_pkg::HGT_W-1:0]  image_height,
  output pix2x2_pkg::scan_t                  pos
);

  logic [pix2x2_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [pix2x2_pkg::COL_W-1:0] col_r, col_nxt;
  logic [pix2x2_pkg::WID_W-1:0] w_eff, col_inc;
  logic [pix2x2_pkg::HGT_W-1:0] h_eff, row_inc;
  logic                         last_col, last_row;

  always_comb begin
    if (image_width == '0) begin
      w_eff = pix2x2_pkg::WID_W'(1);
    end else if (image_width > pix2x2_pkg::WID_W'(pix2x2_pkg::MAX_WIDTH)) begin
      w_eff = pix2x2_pkg::WID_W'(pix2x2_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = pix2x2_pkg::HGT_W'(1);
    end else if (image_height > pix2x2_pkg::HGT_W'(pix2x2_pkg::MAX_HEIGHT)) begin
      h_eff = pix2x2_pkg::HGT_W'(pix2x2_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign col_inc  = {1'b0, col_r} + pix2x2_pkg::WID_W'(1);
  assign row_inc  = {1'b0, row_r} + pix2x2_pkg::HGT_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);

  always_comb begin
    pos.row  = row_r;
    pos.col  = col_r;
    pos.fend = last_col && last_row;
    if (!row_r[0]) begin
      pos.kind = last_row ? pix2x2_pkg::KIND_ONE : pix2x2_pkg::KIND_STORE;
    end else if (!col_r[0]) begin
      pos.kind = last_col ? pix2x2_pkg::KIND_TWO : pix2x2_pkg::KIND_LEFT;
    end else begin
      pos.kind = pix2x2_pkg::KIND_FOUR;
    end
  end

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_inc[pix2x2_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[pix2x2_pkg::COL_W-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (advance) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule
`default_nettype wire

### src/pix2x2_burst.sv
// Result register: plays out the one, two or four beats of a loaded burst.
`default_nettype none
module pix2x2_burst (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire pix2x2_pkg::burst_t            load_data,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [pix2x2_pkg::PIX_W-1:0]  out_pixel_out,
  output logic      [pix2x2_pkg::ROW_W-1:0]  out_row,
  output logic      [pix2x2_pkg::COL_W-1:0]  out_col,
  output logic                               out_last_of_run,
  output logic                               out_frame_end
);

  pix2x2_pkg::burst_t b_r;
  logic               valid_r;
  logic [1:0]         beat_r;
  logic               beat_last, row_top, col_left;

  always_comb begin
    beat_last = 1'b1;
    row_top   = 1'b0;
    col_left  = 1'b0;
    case (b_r.kind)
      pix2x2_pkg::KIND_FOUR: begin
        beat_last = (beat_r == 2'd3);
        row_top   = !beat_r[1];
        col_left  = !beat_r[0];
      end
      pix2x2_pkg::KIND_TWO: begin
        beat_last = beat_r[0];
        row_top   = !beat_r[0];
      end
      default: begin
        beat_last = 1'b1;
      end
    endcase
  end

  assign out_valid       = valid_r;
  assign out_pixel_out   = (beat_r == 2'd0) ? b_r.val0 : b_r.val1;
  assign out_row         = row_top ? b_r.row - pix2x2_pkg::ROW_W'(1) : b_r.row;
  assign out_col         = col_left ? b_r.col - pix2x2_pkg::COL_W'(1) : b_r.col;
  assign out_last_of_run = beat_last;
  assign out_frame_end   = beat_last && b_r.fend;
  assign free            = !valid_r || (!out_stall && beat_last);

  always_ff @(posedge clk) begin
    if (load) begin
      b_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
    end else if (valid_r && !out_stall) begin
      if (beat_last) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### src/pixelate_2x2_block_average.sv
// Top level of the 2x2 block-average mosaic on a raster pixel stream.
// Grey pixels enter one beat at a time in raster order over a frame of
// image_width x image_height (0 acts as 1, sizes above 512 x 4096 are held
// at the maximum). Even-row pixels, but for a last row, go into a 512-entry
// line store and make no result. In odd rows the even-column pixel is held;
// the odd-column pixel closes a 2x2 block and yields four result beats, all
// carrying the truncated block average, at (r-1,c-1), (r-1,c), (r,c-1),
// (r,c). Pixels of blocks cut off by an odd width or height come out
// unchanged at their own place. The last beat of each burst carries
// last_of_run, and the final beat of the frame also carries frame_end.
// Rate: even rows and the holding pixels run at one per clock unless the
// input register waits on the result register; a burst occupies the single
// result register until out_stall lets its last beat go. The input register
// takes the next pixel while a burst drains. A pixel passes the input
// register, then the result register, before its first result beat.
// The line store needs no clearing after reset; configure only while idle.
`default_nettype none
module pixelate_2x2_block_average (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [pix2x2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pix2x2_pkg::CFG_W-1:0]      cfg_data,
  // pixel input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pix2x2_pkg::PIX_W-1:0]      in_pixel_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [pix2x2_pkg::PIX_W-1:0]      out_pixel_out,
  output logic      [pix2x2_pkg::ROW_W-1:0]      out_row,
  output logic      [pix2x2_pkg::COL_W-1:0]      out_col,
  output logic                                   out_last_of_run,
  output logic                                   out_frame_end
);

  logic [pix2x2_pkg::WID_W-1:0] width_r;
  logic [pix2x2_pkg::HGT_W-1:0] height_r;

  // Input register (stage A)
  logic                          a_valid_r;
  pix2x2_pkg::scan_t             a_pos_r;
  logic [pix2x2_pkg::PIX_W-1:0]  a_pix_r;
  logic [pix2x2_pkg::PIX_W-1:0]  top_rd;     // store read for this column

  // Block context from the preceding odd-row, even-column pixel
  logic [pix2x2_pkg::PIX_W-1:0]  left_r;
  logic [pix2x2_pkg::PIX_W-1:0]  top_left_r;

  pix2x2_pkg::scan_t             pos;
  pix2x2_pkg::burst_t            load_data;
  logic                          accept, a_adv, a_has_res, b_free;
  logic [pix2x2_pkg::SUM_W-1:0]  sum;
  logic [pix2x2_pkg::PIX_W-1:0]  avg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pix2x2_pkg::WIDTH_RST;
      height_r <= pix2x2_pkg::HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pix2x2_pkg::REG_WIDTH:  width_r  <= cfg_data[pix2x2_pkg::WID_W-1:0];
        pix2x2_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pix2x2_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .image_width  (width_r),
    .image_height (height_r),
    .pos          (pos)
  );

  // Read the store at every accepted column; write only on storing rows
  pix2x2_line_store u_store (
    .clk       (clk),
    .wr_en     (accept && (pos.kind == pix2x2_pkg::KIND_STORE)),
    .rd_en     (accept),
    .addr      (pos.col),
    .wr_data   (in_pixel_in),
    .rd_data_r (top_rd)
  );

  // Advance stage A when it makes no result or the result register frees up
  assign a_has_res = (a_pos_r.kind == pix2x2_pkg::KIND_ONE) ||
                     (a_pos_r.kind == pix2x2_pkg::KIND_TWO) ||
                     (a_pos_r.kind == pix2x2_pkg::KIND_FOUR);
  assign a_adv     = a_valid_r && (!a_has_res || b_free);
  assign in_stall  = a_valid_r && !a_adv;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pos_r <= pos;
      a_pix_r <= in_pixel_in;
    end
  end

  // Hold the left column of the block until its odd-column partner arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      top_left_r <= '0;
    end else if (a_adv && (a_pos_r.kind == pix2x2_pkg::KIND_LEFT)) begin
      left_r     <= a_pix_r;
      top_left_r <= top_rd;
    end
  end

  assign sum = pix2x2_pkg::SUM_W'(top_left_r) + pix2x2_pkg::SUM_W'(top_rd)
             + pix2x2_pkg::SUM_W'(left_r) + pix2x2_pkg::SUM_W'(a_pix_r);
  assign avg = sum[pix2x2_pkg::SUM_W-1:2];

  always_comb begin
    load_data.kind = a_pos_r.kind;
    load_data.row  = a_pos_r.row;
    load_data.col  = a_pos_r.col;
    load_data.fend = a_pos_r.fend;
    case (a_pos_r.kind)
      pix2x2_pkg::KIND_FOUR: begin
        load_data.val0 = avg;
        load_data.val1 = avg;
      end
      pix2x2_pkg::KIND_TWO: begin
        load_data.val0 = top_rd;
        load_data.val1 = a_pix_r;
      end
      default: begin
        load_data.val0 = a_pix_r;
        load_data.val1 = a_pix_r;
      end
    endcase
  end

  pix2x2_burst u_burst (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (a_adv && a_has_res),
    .load_data       (load_data),
    .free            (b_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule
`default_nettype wire
